// ===== sv/blsf_pkg.sv =====
`timescale 1ns / 1ps

package blsf_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_FRAME_BASE     = 3'd0;
    localparam logic [2:0] CFG_SCREEN_WIDTH   = 3'd1;
    localparam logic [2:0] CFG_SCREEN_HEIGHT  = 3'd2;
    localparam logic [2:0] CFG_ROW_PITCH      = 3'd3;
    localparam logic [2:0] CFG_BITS_PER_PIXEL = 3'd4;
    localparam logic [2:0] CFG_SOURCE_WIDTH   = 3'd5;
    localparam logic [2:0] CFG_SOURCE_HEIGHT  = 3'd6;
    localparam logic [2:0] CFG_FADE_ALPHA     = 3'd7;

    // square side: 22 percent of the smaller screen side, clamped
    localparam logic [4:0]  SIDE_PCT    = 5'd22;
    // ceil(2^24 / 100), exact for products below 199799
    localparam logic [17:0] RECIP_100   = 18'd167773;
    localparam int          RECIP_SHIFT = 24;
    localparam logic [9:0]  SIDE_MIN    = 10'd64;
    localparam logic [9:0]  SIDE_MAX    = 10'd800;

    localparam logic [8:0]  WEIGHT_ONE   = 9'd256;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    localparam logic [2:0]  BYTES_3    = 3'd3;
    localparam logic [2:0]  BYTES_4    = 3'd4;
    localparam logic [2:0]  BYTES_NONE = 3'd0;

    localparam int QUEUE_DEPTH = 32;
    localparam int OUT_DEPTH   = 4;

    typedef struct packed {
        logic [47:0] frame_base;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [14:0] row_pitch;
        logic [5:0]  bits_per_pixel;
        logic [8:0]  source_width;
        logic [8:0]  source_height;
        logic [7:0]  fade_alpha;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  byte_count;
        logic [23:0] pixel_value;
        logic [47:0] byte_address;
        logic        write_enable;
    } res_t;

endpackage

// ===== sv/blsf_ram.sv =====
`timescale 1ns / 1ps

module blsf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

// ===== sv/blsf_queue.sv =====
`timescale 1ns / 1ps

module blsf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;

    // pointer bookkeeping
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_reg];
    assign valid = (cnt_reg != '0);
    assign full  = (cnt_reg == CNTW'(DEPTH));

endmodule

// ===== sv/blsf_front.sv =====
`timescale 1ns / 1ps

module blsf_front #(
    parameter int MAX_SOURCE_SIDE = 256,
    parameter int SOURCE_TEXELS   = 65536,
    parameter int EW              = 213
) (
    input  logic           clk,
    input  logic           rst_n,
    input  blsf_pkg::cfg_t cfg,
    input  logic           in_valid,
    input  logic           action,
    input  logic [15:0]    texel_index,
    input  logic [23:0]    texel_rgb,
    input  logic [9:0]     out_column,
    input  logic [9:0]     out_row,
    output logic           out_valid,
    output logic [EW-1:0]  out_data
);

    import blsf_pkg::*;

    localparam int SWW = $clog2(MAX_SOURCE_SIDE + 1);
    localparam int CW  = $clog2(MAX_SOURCE_SIDE);
    localparam int QW  = CW + 8;
    localparam int NW  = CW + 18;
    localparam int AW  = $clog2(SOURCE_TEXELS);
    localparam int TAW = CW + SWW + 1;

    localparam int ST_A   = 0;
    localparam int ST_B   = 1;
    localparam int ST_C   = 2;
    localparam int ST_D   = 3;
    localparam int ST_E   = 4;
    localparam int ST_F   = 5;
    localparam int ST_DIV = 6;
    localparam int ST_G   = ST_DIV + QW;
    localparam int NFR    = ST_G + 1;

    typedef struct packed {
        logic                  is_load;
        logic [15:0]           tindex;
        logic [23:0]           rgb;
        logic [9:0]            col;
        logic [9:0]            row;
        logic [17:0]           prod;
        logic [10:0]           side_raw;
        logic [9:0]            side;
        logic [2:0]            bpp;
        logic [SWW-1:0]        sw;
        logic [SWW-1:0]        sh;
        logic                  in_sq;
        logic signed [14:0]    tx;
        logic signed [14:0]    ty;
        logic [NW-1:0]         numx;
        logic [NW-1:0]         numy;
        logic [9:0]            den;
        logic [10:0]           remx;
        logic [10:0]           remy;
        logic [QW-1:0]         qx;
        logic [QW-1:0]         qy;
        logic                  hit;
        logic [27:0]           rowoff;
        logic [47:0]           addr;
        logic [CW-1:0]         x0;
        logic [CW-1:0]         x1;
        logic [CW-1:0]         y0;
        logic [CW-1:0]         y1;
        logic [7:0]            fx;
        logic [7:0]            fy;
        logic [TAW-1:0]        rb0;
        logic [TAW-1:0]        rb1;
    } fr_t;

    typedef struct packed {
        logic                  is_load;
        logic                  hit;
        logic [23:0]           rgb;
        logic [47:0]           addr;
        logic [2:0]            bpp;
        logic [3:0]            tok;
        logic [3:0][AW-1:0]    ta;
        logic [3:0][16:0]      w;
    } ent_t;

    fr_t  st_reg  [NFR];
    fr_t  st_next [NFR];
    ent_t ent_reg, ent_next;
    logic [NFR:0] v_reg;

    function automatic logic [SWW-1:0] clamp_side(input logic [8:0] v);
        int unsigned t;
        t = 32'(v);
        if (t == 0)
        begin
            t = 1;
        end
        if (t > MAX_SOURCE_SIDE)
        begin
            t = MAX_SOURCE_SIDE;
        end
        return SWW'(t);
    endfunction

    // stage a: capture item, smaller screen side times percentage
    always_comb
    begin
        logic [12:0] short_side;
        st_next[ST_A] = '0;
        short_side = (cfg.screen_width < cfg.screen_height) ? cfg.screen_width
                                                            : cfg.screen_height;
        st_next[ST_A].is_load = !action;
        st_next[ST_A].tindex  = texel_index;
        st_next[ST_A].rgb     = texel_rgb;
        st_next[ST_A].col     = out_column;
        st_next[ST_A].row     = out_row;
        st_next[ST_A].prod    = 18'(short_side) * 18'(SIDE_PCT);
    end

    // stage b: divide by 100 through reciprocal, decode format, clamp source size
    always_comb
    begin
        logic [35:0] q;
        st_next[ST_B] = st_reg[ST_A];
        q = 36'(st_reg[ST_A].prod) * 36'(RECIP_100);
        st_next[ST_B].side_raw = 11'(q >> RECIP_SHIFT);
        st_next[ST_B].bpp = (cfg.bits_per_pixel[5:3] == BYTES_NONE) ? BYTES_4
                                                                    : cfg.bits_per_pixel[5:3];
        st_next[ST_B].sw = clamp_side(cfg.source_width);
        st_next[ST_B].sh = clamp_side(cfg.source_height);
    end

    // stage c: clamp the square side
    always_comb
    begin
        st_next[ST_C] = st_reg[ST_B];
        if (st_reg[ST_B].side_raw < 11'(SIDE_MIN))
        begin
            st_next[ST_C].side = SIDE_MIN;
        end
        else if (st_reg[ST_B].side_raw > 11'(SIDE_MAX))
        begin
            st_next[ST_C].side = SIDE_MAX;
        end
        else
        begin
            st_next[ST_C].side = st_reg[ST_B].side_raw[9:0];
        end
    end

    // stage d: centered target position, numerators of the source mapping
    always_comb
    begin
        logic signed [14:0] dx, dy, sx, sy;
        logic [CW+9:0]      mx, my;
        st_next[ST_D] = st_reg[ST_C];
        dx = $signed({2'b00, cfg.screen_width}) - $signed({5'b00000, st_reg[ST_C].side});
        dy = $signed({2'b00, cfg.screen_height}) - $signed({5'b00000, st_reg[ST_C].side});
        // halve rounding toward zero
        sx = (dx + $signed({14'd0, dx[14]})) >>> 1;
        sy = (dy + $signed({14'd0, dy[14]})) >>> 1;
        st_next[ST_D].tx = sx + $signed({5'b00000, st_reg[ST_C].col});
        st_next[ST_D].ty = sy + $signed({5'b00000, st_reg[ST_C].row});
        st_next[ST_D].in_sq = (st_reg[ST_C].col < st_reg[ST_C].side)
                           && (st_reg[ST_C].row < st_reg[ST_C].side);
        mx = (CW+10)'(st_reg[ST_C].col) * (CW+10)'(CW'(st_reg[ST_C].sw - 1'b1));
        my = (CW+10)'(st_reg[ST_C].row) * (CW+10)'(CW'(st_reg[ST_C].sh - 1'b1));
        st_next[ST_D].numx = {mx, 8'd0};
        st_next[ST_D].numy = {my, 8'd0};
        st_next[ST_D].den  = st_reg[ST_C].side - 1'b1;
    end

    // stage e: write qualification, row offset, divider seed
    always_comb
    begin
        logic onx, ony;
        st_next[ST_E] = st_reg[ST_D];
        onx = !st_reg[ST_D].tx[14]
           && (st_reg[ST_D].tx < $signed({2'b00, cfg.screen_width}));
        ony = !st_reg[ST_D].ty[14]
           && (st_reg[ST_D].ty < $signed({2'b00, cfg.screen_height}));
        st_next[ST_E].hit = st_reg[ST_D].in_sq && onx && ony
                         && (cfg.frame_base != '0)
                         && ((st_reg[ST_D].bpp == BYTES_3) || (st_reg[ST_D].bpp == BYTES_4));
        st_next[ST_E].rowoff = 28'(st_reg[ST_D].ty[12:0]) * 28'(cfg.row_pitch);
        st_next[ST_E].remx = 11'(st_reg[ST_D].numx[NW-1:QW]);
        st_next[ST_E].remy = 11'(st_reg[ST_D].numy[NW-1:QW]);
        st_next[ST_E].qx = '0;
        st_next[ST_E].qy = '0;
    end

    // stage f: frame buffer byte address
    always_comb
    begin
        st_next[ST_F] = st_reg[ST_E];
        st_next[ST_F].addr = cfg.frame_base + 48'(st_reg[ST_E].rowoff)
                           + 48'(16'(st_reg[ST_E].tx[12:0]) * 16'(st_reg[ST_E].bpp));
    end

    // restoring divider, one quotient bit per stage for both axes
    for (genvar i = 0; i < QW; i++)
    begin : g_div
        localparam int B = QW - 1 - i;
        always_comb
        begin
            logic [11:0] trx, try_y;
            st_next[ST_DIV+i] = st_reg[ST_DIV+i-1];
            trx   = {st_reg[ST_DIV+i-1].remx, st_reg[ST_DIV+i-1].numx[B]};
            try_y = {st_reg[ST_DIV+i-1].remy, st_reg[ST_DIV+i-1].numy[B]};
            if (trx >= {2'b00, st_reg[ST_DIV+i-1].den})
            begin
                st_next[ST_DIV+i].remx  = 11'(trx - {2'b00, st_reg[ST_DIV+i-1].den});
                st_next[ST_DIV+i].qx[B] = 1'b1;
            end
            else
            begin
                st_next[ST_DIV+i].remx  = trx[10:0];
                st_next[ST_DIV+i].qx[B] = 1'b0;
            end
            if (try_y >= {2'b00, st_reg[ST_DIV+i-1].den})
            begin
                st_next[ST_DIV+i].remy  = 11'(try_y - {2'b00, st_reg[ST_DIV+i-1].den});
                st_next[ST_DIV+i].qy[B] = 1'b1;
            end
            else
            begin
                st_next[ST_DIV+i].remy  = try_y[10:0];
                st_next[ST_DIV+i].qy[B] = 1'b0;
            end
        end
    end

    // stage g: neighbor coordinates, fractions, row bases
    always_comb
    begin
        fr_t s;
        s = st_reg[ST_G-1];
        st_next[ST_G] = s;
        st_next[ST_G].x0 = s.qx[QW-1:8];
        st_next[ST_G].y0 = s.qy[QW-1:8];
        st_next[ST_G].fx = s.qx[7:0];
        st_next[ST_G].fy = s.qy[7:0];
        st_next[ST_G].x1 = (SWW'(s.qx[QW-1:8]) < SWW'(s.sw - 1'b1)) ? s.qx[QW-1:8] + 1'b1
                                                                    : s.qx[QW-1:8];
        st_next[ST_G].y1 = (SWW'(s.qy[QW-1:8]) < SWW'(s.sh - 1'b1)) ? s.qy[QW-1:8] + 1'b1
                                                                    : s.qy[QW-1:8];
        st_next[ST_G].rb0 = TAW'(s.qy[QW-1:8]) * TAW'(s.sw);
        st_next[ST_G].rb1 = TAW'(st_next[ST_G].y1) * TAW'(s.sw);
    end

    // queue entry: texel addresses, range checks, bilinear weights
    always_comb
    begin
        fr_t          s;
        logic [TAW-1:0] a00, a10, a01, a11;
        logic [8:0]   ifx, ify;
        s = st_reg[ST_G];
        a00 = s.rb0 + TAW'(s.x0);
        a10 = s.rb0 + TAW'(s.x1);
        a01 = s.rb1 + TAW'(s.x0);
        a11 = s.rb1 + TAW'(s.x1);
        ifx = WEIGHT_ONE - 9'(s.fx);
        ify = WEIGHT_ONE - 9'(s.fy);
        ent_next.is_load = s.is_load;
        ent_next.hit     = s.hit;
        ent_next.rgb     = s.rgb;
        ent_next.addr    = s.addr;
        ent_next.bpp     = s.bpp;
        ent_next.tok[1]  = 32'(a10) < SOURCE_TEXELS;
        ent_next.tok[2]  = 32'(a01) < SOURCE_TEXELS;
        ent_next.tok[3]  = 32'(a11) < SOURCE_TEXELS;
        ent_next.ta[1]   = AW'(a10);
        ent_next.ta[2]   = AW'(a01);
        ent_next.ta[3]   = AW'(a11);
        if (s.is_load)
        begin
            ent_next.tok[0] = 32'(s.tindex) < SOURCE_TEXELS;
            ent_next.ta[0]  = AW'(s.tindex);
        end
        else
        begin
            ent_next.tok[0] = 32'(a00) < SOURCE_TEXELS;
            ent_next.ta[0]  = AW'(a00);
        end
        ent_next.w[0] = 17'(ifx) * 17'(ify);
        ent_next.w[1] = 17'(s.fx) * 17'(ify);
        ent_next.w[2] = 17'(ifx) * 17'(s.fy);
        ent_next.w[3] = 17'(s.fx) * 17'(s.fy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[NFR-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NFR; i++)
        begin
            st_reg[i] <= st_next[i];
        end
        ent_reg <= ent_next;
    end

    assign out_valid = v_reg[NFR];
    assign out_data  = EW'(ent_reg);

endmodule

// ===== sv/blsf_back.sv =====
`timescale 1ns / 1ps

module blsf_back #(
    parameter int SOURCE_TEXELS = 65536,
    parameter int EW            = 213
) (
    input  logic           clk,
    input  logic           rst_n,
    input  blsf_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  logic [EW-1:0]  q_data,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [79:0]    m_tdata
);

    import blsf_pkg::*;

    localparam int AW = $clog2(SOURCE_TEXELS);
    localparam int CRW = $clog2(OUT_DEPTH + 1);
    localparam logic [1:0] TAP_FIRST = 2'd0;
    localparam logic [1:0] TAP_LAST  = 2'd3;

    typedef struct packed {
        logic                  is_load;
        logic                  hit;
        logic [23:0]           rgb;
        logic [47:0]           addr;
        logic [2:0]            bpp;
        logic [3:0]            tok;
        logic [3:0][AW-1:0]    ta;
        logic [3:0][16:0]      w;
    } ent_t;

    typedef struct packed {
        logic [1:0]  k;
        logic        hit;
        logic        ok;
        logic [16:0] w;
        logic [47:0] addr;
        logic [2:0]  bpp;
    } rd_t;

    typedef struct packed {
        logic        hit;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [47:0] addr;
        logic [2:0]  bpp;
    } fd_t;

    ent_t           head, cur_reg, cur_next;
    logic           busy_reg, busy_next;
    logic [1:0]     k_reg, k_next;
    logic [CRW-1:0] credit_reg, credit_next;
    logic           start, start_render;
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [23:0]    mem_rdata;
    rd_t            rd_reg, rd_next;
    logic           rd_vld_reg, rd_vld_next;
    logic [23:0]    acc_r_reg, acc_g_reg, acc_b_reg;
    logic [23:0]    acc_r_next, acc_g_next, acc_b_next;
    fd_t            fd_reg, fd_next;
    logic           fd_vld_reg, fd_vld_next;
    res_t           res_in, res_out;
    logic           out_pop, ofifo_full;

    assign head = ent_t'(q_data);
    assign start = !busy_reg && q_valid && (head.is_load || (credit_reg < CRW'(OUT_DEPTH)));
    assign start_render = start && !head.is_load;
    assign q_pop = start;

    // single-port sequencer: one write per load, four reads per hit, else one
    always_comb
    begin
        busy_next   = busy_reg;
        k_next      = k_reg;
        cur_next    = cur_reg;
        mem_we      = 1'b0;
        mem_addr    = head.ta[0];
        rd_vld_next = 1'b0;
        rd_next     = rd_reg;
        if (busy_reg)
        begin
            mem_addr     = cur_reg.ta[k_reg];
            rd_vld_next  = 1'b1;
            rd_next.k    = k_reg;
            rd_next.hit  = 1'b1;
            rd_next.ok   = cur_reg.tok[k_reg];
            rd_next.w    = cur_reg.w[k_reg];
            rd_next.addr = cur_reg.addr;
            rd_next.bpp  = cur_reg.bpp;
            k_next       = k_reg + 1'b1;
            if (k_reg == TAP_LAST)
            begin
                busy_next = 1'b0;
            end
        end
        else if (start)
        begin
            if (head.is_load)
            begin
                mem_we = head.tok[0];
            end
            else
            begin
                rd_vld_next  = 1'b1;
                rd_next.k    = TAP_FIRST;
                rd_next.hit  = head.hit;
                rd_next.ok   = head.tok[0];
                rd_next.w    = head.w[0];
                rd_next.addr = head.addr;
                rd_next.bpp  = head.bpp;
                if (head.hit)
                begin
                    busy_next = 1'b1;
                    k_next    = TAP_FIRST + 1'b1;
                    cur_next  = head;
                end
            end
        end
    end

    blsf_ram #(
        .WIDTH (24),
        .DEPTH (SOURCE_TEXELS)
    ) u_image (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (head.rgb),
        .rdata (mem_rdata)
    );

    // weighted accumulation as the texels return
    always_comb
    begin
        logic [23:0] t;
        logic [23:0] pr, pg, pb;
        t  = rd_reg.ok ? mem_rdata : 24'd0;
        pr = 24'(25'(t[23:16]) * 25'(rd_reg.w));
        pg = 24'(25'(t[15:8]) * 25'(rd_reg.w));
        pb = 24'(25'(t[7:0]) * 25'(rd_reg.w));
        acc_r_next = acc_r_reg;
        acc_g_next = acc_g_reg;
        acc_b_next = acc_b_reg;
        if (rd_vld_reg)
        begin
            acc_r_next = (rd_reg.k == TAP_FIRST) ? pr : acc_r_reg + pr;
            acc_g_next = (rd_reg.k == TAP_FIRST) ? pg : acc_g_reg + pg;
            acc_b_next = (rd_reg.k == TAP_FIRST) ? pb : acc_b_reg + pb;
        end
        fd_vld_next  = rd_vld_reg && ((rd_reg.k == TAP_LAST) || !rd_reg.hit);
        fd_next.hit  = rd_reg.hit;
        fd_next.r    = acc_r_next[23:16];
        fd_next.g    = acc_g_next[23:16];
        fd_next.b    = acc_b_next[23:16];
        fd_next.addr = rd_reg.addr;
        fd_next.bpp  = rd_reg.bpp;
    end

    // fade and result formatting
    always_comb
    begin
        logic [7:0] r, g, b;
        r = fd_reg.r;
        g = fd_reg.g;
        b = fd_reg.b;
        if (cfg.fade_alpha < ALPHA_OPAQUE)
        begin
            r = 8'((16'(fd_reg.r) * 16'(cfg.fade_alpha)) >> 8);
            g = 8'((16'(fd_reg.g) * 16'(cfg.fade_alpha)) >> 8);
            b = 8'((16'(fd_reg.b) * 16'(cfg.fade_alpha)) >> 8);
        end
        res_in = '0;
        if (fd_reg.hit)
        begin
            res_in.write_enable = 1'b1;
            res_in.byte_address = fd_reg.addr;
            res_in.pixel_value  = {r, g, b};
            res_in.byte_count   = fd_reg.bpp;
        end
    end

    // output slots are reserved when a render starts
    always_comb
    begin
        credit_next = credit_reg;
        if (start_render && !out_pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (out_pop && !start_render)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            k_reg      <= TAP_FIRST;
            credit_reg <= '0;
            rd_vld_reg <= 1'b0;
            fd_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            k_reg      <= k_next;
            credit_reg <= credit_next;
            rd_vld_reg <= rd_vld_next;
            fd_vld_reg <= fd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        rd_reg    <= rd_next;
        acc_r_reg <= acc_r_next;
        acc_g_reg <= acc_g_next;
        acc_b_reg <= acc_b_next;
        fd_reg    <= fd_next;
    end

    assign out_pop = m_tvalid && m_tready;

    blsf_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fd_vld_reg),
        .wdata (res_in),
        .pop   (out_pop),
        .rdata (res_out),
        .valid (m_tvalid),
        .full  (ofifo_full)
    );

    assign m_tdata = {4'd0, res_out};

    // checks
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CRW'(OUT_DEPTH))
        else $error("output reservations exceed slots");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !q_pop)
        else $error("queue popped during texel reads");

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        fd_vld_reg |-> !ofifo_full)
        else $error("result pushed into full output queue");

    a_tap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && k_reg == TAP_LAST) |=> !busy_reg)
        else $error("sequencer ran past last tap");

endmodule

// ===== sv/bilinear_logo_scaler_fade.sv =====
`timescale 1ns / 1ps

// Bilinear logo scaler with fade.
// Input stream (s_*): s_tuser is the action, 0 loads one source texel into the
// on-chip image, 1 renders one pixel of the centered square. Output stream (m_*)
// carries one result per render request: write enable, frame buffer byte
// address, packed 0xRRGGBB pixel and byte count; loads give no result.
// The config port writes one register per cycle with cfg_we; write only while
// the block is idle.
// Front end: a fixed pipeline of 16 + log2(MAX_SOURCE_SIDE) stages (24 at the
// default) computes the square side, target address, source position through a
// one-bit-per-stage divider and the bilinear weights, then feeds a 32-entry queue.
// Back end: a written pixel reads its four neighbor texels one after another on
// the single-port source memory; a suppressed render or a load needs one access.
// No new request starts until a written pixel's texel reads are done; loads are
// taken one per cycle while no texel reads are pending.
// Reset empties all pipelines and queues and restores the register defaults;
// the source image is undefined until loaded. When m_tready is low, results
// collect in a 4-entry output queue, then the back end and the input queue
// fill and s_tready drops.
module bilinear_logo_scaler_fade #(
    parameter int MAX_SOURCE_SIDE = 256,
    parameter int SOURCE_TEXELS   = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // texel_index, texel_red, texel_green, texel_blue, out_column, out_row
    input  logic [63:0] s_tdata,
    // action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // write_enable, byte_address, pixel_value, byte_count
    output logic [79:0] m_tdata
);

    import blsf_pkg::*;

    localparam int AW = $clog2(SOURCE_TEXELS);
    localparam int EW = 149 + 4 * AW;
    localparam int OCW = $clog2(QUEUE_DEPTH + 1);

    cfg_t           cfg_reg;
    logic           s_acc;
    logic           fr_valid;
    logic [EW-1:0]  fr_data;
    logic [EW-1:0]  q_data;
    logic           q_valid, q_pop, q_full;
    logic [OCW-1:0] occ_reg, occ_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_base     <= '0;
            cfg_reg.screen_width   <= '0;
            cfg_reg.screen_height  <= '0;
            cfg_reg.row_pitch      <= '0;
            cfg_reg.bits_per_pixel <= 6'd32;
            cfg_reg.source_width   <= 9'd256;
            cfg_reg.source_height  <= 9'd256;
            cfg_reg.fade_alpha     <= ALPHA_OPAQUE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_BASE:     cfg_reg.frame_base     <= cfg_data;
                CFG_SCREEN_WIDTH:   cfg_reg.screen_width   <= cfg_data[12:0];
                CFG_SCREEN_HEIGHT:  cfg_reg.screen_height  <= cfg_data[12:0];
                CFG_ROW_PITCH:      cfg_reg.row_pitch      <= cfg_data[14:0];
                CFG_BITS_PER_PIXEL: cfg_reg.bits_per_pixel <= cfg_data[5:0];
                CFG_SOURCE_WIDTH:   cfg_reg.source_width   <= cfg_data[8:0];
                CFG_SOURCE_HEIGHT:  cfg_reg.source_height  <= cfg_data[8:0];
                CFG_FADE_ALPHA:     cfg_reg.fade_alpha     <= cfg_data[7:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // requests in flight or queued; the queue can always take the front output
    assign s_tready = (occ_reg < OCW'(QUEUE_DEPTH));
    assign s_acc = s_tvalid && s_tready;

    always_comb
    begin
        occ_next = occ_reg;
        if (s_acc && !q_pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (q_pop && !s_acc)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    blsf_front #(
        .MAX_SOURCE_SIDE (MAX_SOURCE_SIDE),
        .SOURCE_TEXELS   (SOURCE_TEXELS),
        .EW              (EW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_acc),
        .action      (s_tuser),
        .texel_index (s_tdata[15:0]),
        .texel_rgb   ({s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]}),
        .out_column  (s_tdata[49:40]),
        .out_row     (s_tdata[59:50]),
        .out_valid   (fr_valid),
        .out_data    (fr_data)
    );

    blsf_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_valid),
        .wdata (fr_data),
        .pop   (q_pop),
        .rdata (q_data),
        .valid (q_valid),
        .full  (q_full)
    );

    blsf_back #(
        .SOURCE_TEXELS (SOURCE_TEXELS),
        .EW            (EW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCW'(QUEUE_DEPTH))
        else $error("request count exceeds queue depth");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        fr_valid |-> !q_full)
        else $error("front pushed into full queue");

endmodule

// ===== test/blsf_checker.sv =====
`timescale 1ns / 1ps

module blsf_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    output int          errors,
    output int          pending
);

    import blsf_pkg::*;

    // shadow of the register file and the source image
    cfg_t        regs;
    logic [23:0] texels [0:65535];
    res_t        expected_pixels [$];

    assign pending = expected_pixels.size();

    function automatic int unsigned clamp_src(input logic [8:0] s);
        if (s == 0) return 1;
        if (s > 256) return 256;
        return 32'(s);
    endfunction

    function automatic logic [7:0] blend(input logic [7:0] p, input logic [7:0] q,
                                         input logic [7:0] r, input logic [7:0] s,
                                         input int unsigned fx, input int unsigned fy);
        int unsigned sum;
        sum = p * (256 - fx) * (256 - fy) + q * fx * (256 - fy)
            + r * (256 - fx) * fy + s * fx * fy;
        return sum[23:16];
    endfunction

    // expected write for one rendered pixel of the centered square
    function automatic res_t render_pixel(input logic [9:0] col, input logic [9:0] row);
        res_t        res;
        int          short_side, side, bpp, sx, sy, tx, ty, sw, sh;
        int unsigned gx, gy, x0, y0, x1, y1, fx, fy;
        logic [23:0] t00, t10, t01, t11;
        logic [7:0]  r, g, b;
        longint      addr;
        res = '0;
        short_side = (regs.screen_width < regs.screen_height) ?
                     int'(regs.screen_width) : int'(regs.screen_height);
        side = short_side * 22 / 100;
        if (side < 64) side = 64;
        if (side > 800) side = 800;
        if (col >= side || row >= side) return res;
        bpp = int'(regs.bits_per_pixel) / 8;
        if (bpp == 0) bpp = 4;
        sx = (int'(regs.screen_width) - side) / 2;
        sy = (int'(regs.screen_height) - side) / 2;
        tx = sx + int'(col);
        ty = sy + int'(row);
        if (tx < 0 || tx >= int'(regs.screen_width) || ty < 0 ||
            ty >= int'(regs.screen_height))
            return res;
        if (regs.frame_base == 0 || (bpp != 3 && bpp != 4)) return res;
        sw = int'(clamp_src(regs.source_width));
        sh = int'(clamp_src(regs.source_height));
        gx = 32'((longint'(col) * (sw - 1) * 256) / (side - 1));
        gy = 32'((longint'(row) * (sh - 1) * 256) / (side - 1));
        x0 = gx >> 8;
        y0 = gy >> 8;
        x1 = (x0 < sw - 1) ? x0 + 1 : x0;
        y1 = (y0 < sh - 1) ? y0 + 1 : y0;
        fx = gx & 8'hFF;
        fy = gy & 8'hFF;
        t00 = texels[y0 * sw + x0];
        t10 = texels[y0 * sw + x1];
        t01 = texels[y1 * sw + x0];
        t11 = texels[y1 * sw + x1];
        r = blend(t00[23:16], t10[23:16], t01[23:16], t11[23:16], fx, fy);
        g = blend(t00[15:8], t10[15:8], t01[15:8], t11[15:8], fx, fy);
        b = blend(t00[7:0], t10[7:0], t01[7:0], t11[7:0], fx, fy);
        // fade dims every channel by alpha/256 unless alpha is opaque
        if (regs.fade_alpha != ALPHA_OPAQUE)
        begin
            r = 8'((16'(r) * regs.fade_alpha) >> 8);
            g = 8'((16'(g) * regs.fade_alpha) >> 8);
            b = 8'((16'(b) * regs.fade_alpha) >> 8);
        end
        addr = longint'(regs.frame_base) + longint'(ty) * regs.row_pitch + longint'(tx) * bpp;
        res.write_enable = 1'b1;
        res.byte_address = addr[47:0];
        res.pixel_value  = {r, g, b};
        res.byte_count   = 3'(bpp);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_res;
        res_t got;
        if (!rst_n)
        begin
            regs <= '{frame_base: 0, screen_width: 0, screen_height: 0, row_pitch: 0,
                      bits_per_pixel: 6'd32, source_width: 9'd256, source_height: 9'd256,
                      fade_alpha: ALPHA_OPAQUE};
            errors <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_BASE:     regs.frame_base     <= cfg_data;
                    CFG_SCREEN_WIDTH:   regs.screen_width   <= cfg_data[12:0];
                    CFG_SCREEN_HEIGHT:  regs.screen_height  <= cfg_data[12:0];
                    CFG_ROW_PITCH:      regs.row_pitch      <= cfg_data[14:0];
                    CFG_BITS_PER_PIXEL: regs.bits_per_pixel <= cfg_data[5:0];
                    CFG_SOURCE_WIDTH:   regs.source_width   <= cfg_data[8:0];
                    CFG_SOURCE_HEIGHT:  regs.source_height  <= cfg_data[8:0];
                    CFG_FADE_ALPHA:     regs.fade_alpha     <= cfg_data[7:0];
                    default:            regs                <= regs;
                endcase
            end
            // accepted request: load a texel or predict a pixel
            if (s_tvalid && s_tready)
            begin
                if (!s_tuser)
                    texels[s_tdata[15:0]] = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
                else
                    expected_pixels.push_back(render_pixel(s_tdata[49:40], s_tdata[59:50]));
            end
            // accepted result
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[75:0];
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_res = expected_pixels.pop_front();
                    if (got.write_enable !== exp_res.write_enable)
                        $display("%0t: write_enable expected %0d actual %0d", $time,
                                 exp_res.write_enable, got.write_enable);
                    if (got.byte_address !== exp_res.byte_address)
                        $display("%0t: byte_address expected %h actual %h", $time,
                                 exp_res.byte_address, got.byte_address);
                    if (got.pixel_value !== exp_res.pixel_value)
                        $display("%0t: pixel_value expected %h actual %h", $time,
                                 exp_res.pixel_value, got.pixel_value);
                    if (got.byte_count !== exp_res.byte_count)
                        $display("%0t: byte_count expected %0d actual %0d", $time,
                                 exp_res.byte_count, got.byte_count);
                    if (m_tdata[79:76] !== 4'h0)
                        $display("%0t: padding expected 0 actual %h", $time, m_tdata[79:76]);
                    if (got !== exp_res || m_tdata[79:76] !== 4'h0)
                        errors <= errors + 1;
                end
            end
        end
    end

endmodule

// ===== test/tb_bilinear_logo_scaler_fade.sv =====
`timescale 1ns / 1ps

module tb_bilinear_logo_scaler_fade;
    import blsf_pkg::*;

    localparam int TOTAL_REQUESTS = 1650;
    localparam int QUIET_FROM     = 1450;
    localparam int DRAIN_CYCLES   = 60;
    localparam int STALL_LIMIT    = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    int          errors;
    int          pending;
    int          sent;
    int          idle_cycles = 0;
    logic        quiet;

    bilinear_logo_scaler_fade dut (.*);

    blsf_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // register values for the current phase, indexed by register
    logic [47:0] phase_cfg [0:7];

    function automatic int square_side(input int w, input int h);
        int s;
        s = ((w < h) ? w : h) * 22 / 100;
        if (s < 64) s = 64;
        if (s > 800) s = 800;
        return s;
    endfunction

    function automatic int clamped(input logic [47:0] s);
        if (s == 0) return 1;
        if (s > 256) return 256;
        return int'(s);
    endfunction

    task automatic send_request(input logic action, input logic [63:0] data);
        s_tuser  <= action;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sent++;
        if (sent >= QUIET_FROM) quiet = 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic load_texel(input int idx);
        send_request(1'b0, {24'h0, $urandom_range(0, 1023) == 0 ? 24'h0 :
                     24'($urandom), idx[15:0]});
    endtask

    task automatic render(input int col, input int row);
        send_request(1'b1, {4'h0, row[9:0], col[9:0], 40'($urandom)});
    endtask

    // wait for all results, then let the pipeline empty before touching registers
    task automatic settle_and_configure;
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= phase_cfg[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic load_image;
        int n;
        n = clamped(phase_cfg[CFG_SOURCE_WIDTH]) * clamped(phase_cfg[CFG_SOURCE_HEIGHT]);
        for (int i = 0; i < n; i++) load_texel(i);
    endtask

    task automatic set_phase(input logic [47:0] base, input int w, input int h,
                             input int pitch, input int bits, input int sw,
                             input int sh, input int alpha);
        phase_cfg[CFG_FRAME_BASE]     = base;
        phase_cfg[CFG_SCREEN_WIDTH]   = 48'(w);
        phase_cfg[CFG_SCREEN_HEIGHT]  = 48'(h);
        phase_cfg[CFG_ROW_PITCH]      = 48'(pitch);
        phase_cfg[CFG_BITS_PER_PIXEL] = 48'(bits);
        phase_cfg[CFG_SOURCE_WIDTH]   = 48'(sw);
        phase_cfg[CFG_SOURCE_HEIGHT]  = 48'(sh);
        phase_cfg[CFG_FADE_ALPHA]     = 48'(alpha);
        settle_and_configure();
        load_image();
    endtask

    // corners, edges and positions just outside the square
    task automatic directed_renders;
        int s;
        s = square_side(int'(phase_cfg[CFG_SCREEN_WIDTH]),
                        int'(phase_cfg[CFG_SCREEN_HEIGHT]));
        render(0, 0);
        render(s - 1, s - 1);
        render(s / 2, s / 3);
        render(s, 0);
        render(0, s);
        render(1023, 1023);
    endtask

    // receiver stalls in bursts
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (!quiet)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int s, col, row, n, w, h;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_FRAME_BASE;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        sent        = 0;
        quiet       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero base suppresses every write
        set_phase(48'h0, 1920, 1080, 7680, 32, 4, 4, 255);
        directed_renders();
        // largest everything: address wrap, full side, wide source clamped, black fade
        set_phase(48'hFFFF_FFFF_FFFF, 8191, 8191, 32767, 24, 511, 1, 0);
        directed_renders();
        // tiny screen puts the square off screen; zero source size and zero depth
        set_phase(48'h1, 0, 0, 100, 0, 0, 0, 254);
        directed_renders();
        // depths that give neither 3 nor 4 bytes
        set_phase(48'h1000, 640, 480, 2560, 16, 2, 3, 128);
        directed_renders();
        set_phase(48'h2000, 640, 480, 2560, 63, 3, 2, 1);
        directed_renders();
        // wide, short screen; the square fits on both axes
        set_phase(48'h8000_0000_0000, 4000, 100, 16000, 39, 256, 1, 255);
        directed_renders();

        // random phases
        while (sent < TOTAL_REQUESTS)
        begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) :
                $urandom_range(300, 8191);
            h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) :
                $urandom_range(300, 8191);
            set_phase(($urandom_range(0, 15) == 0) ? 48'h0 : {16'($urandom), 32'($urandom)},
                      w, h, $urandom_range(0, 32767),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) :
                      ($urandom_range(0, 1) ? 24 : 32),
                      $urandom_range(1, 20), $urandom_range(1, 20),
                      $urandom_range(0, 1) ? 255 : $urandom_range(0, 255));
            s = square_side(w, h);
            n = clamped(phase_cfg[CFG_SOURCE_WIDTH]) * clamped(phase_cfg[CFG_SOURCE_HEIGHT]);
            repeat (70)
            begin
                case ($urandom_range(0, 9))
                    0: load_texel($urandom_range(0, 1) ? $urandom_range(0, n - 1) :
                                  $urandom_range(0, 65535));
                    1:
                    begin
                        col = $urandom_range(0, 1023);
                        row = $urandom_range(0, 1) ? $urandom_range(0, 1023) :
                              $urandom_range(0, s - 1);
                        render(col, row);
                    end
                    default:
                    begin
                        col = $urandom_range(0, s - 1);
                        row = $urandom_range(0, s - 1);
                        render(col, row);
                    end
                endcase
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
